FILE: rtl/bntm_pkg.sv
package bntm_pkg;

    localparam int MAX_TRACKS_DEF = 64;
    localparam logic [7:0] MISS_LIMIT_RST = 8'd5;
    localparam logic [7:0] GATE_PCT_RST = 8'd115;

    localparam logic [0:0] CFG_MISS_LIMIT = 1'b0;
    localparam logic [0:0] CFG_GATE_PCT = 1'b1;

    localparam logic [1:0] ST_MATCHED = 2'd0;
    localparam logic [1:0] ST_NEW = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_CLOSED = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture request
        logic scan_rd;    // issue scan read at index
        logic scan_eval;  // evaluate registered read data
        logic gate_mul1;  // first gate product
        logic gate_mul2;  // second gate products
        logic finish_blob;
        logic age_rd;
        logic age_eval;
        logic finish_eof;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_eof;
        logic scan_last;
        logic age_last;
        logic empty;
    } t_sts;

endpackage

FILE: rtl/bntm_datapath.sv
module bntm_datapath
    import bntm_pkg::*;
#(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_command,
    input  logic [11:0] i_center_x,
    input  logic [11:0] i_center_y,
    input  logic [12:0] i_diagonal,
    input  logic [3:0]  i_color_class,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot,
    output logic [6:0]  o_track_count
);

    localparam int IW = $clog2(MAX_TRACKS);
    localparam int CW = $clog2(MAX_TRACKS + 1);

    // track memory, one word per entry
    localparam int EW = 12 + 12 + 4 + 8 + 1;
    logic [EW-1:0] mem [MAX_TRACKS];
    logic [EW-1:0] r_rd;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;
    logic [IW-1:0] mem_ra;

    logic [7:0]  r_miss_limit, r_gate_pct;
    logic        r_cmd;
    logic [11:0] r_x, r_y;
    logic [12:0] r_diag;
    logic [3:0]  r_cls;
    logic [CW-1:0] r_used, r_idx, r_wr;
    logic        r_await, r_init;
    logic        r_found;
    logic [IW-1:0] r_best;
    logic [24:0] r_best_d2;
    logic [15:0] r_gsq;
    logic [49:0] r_lhs, r_rhs;
    logic [1:0]  r_status;
    logic [5:0]  r_slot;
    logic [6:0]  r_cnt;

    // read data fields
    logic [11:0] rd_x, rd_y;
    logic [3:0]  rd_cls;
    logic [7:0]  rd_miss;
    logic        rd_hit;
    assign {rd_x, rd_y, rd_cls, rd_miss, rd_hit} = r_rd;

    // distance of current entry
    logic signed [12:0] dx, dy;
    logic signed [25:0] dx_w, dy_w;
    logic [24:0] d2;
    assign dx = $signed({1'b0, r_x}) - $signed({1'b0, rd_x});
    assign dy = $signed({1'b0, r_y}) - $signed({1'b0, rd_y});
    assign dx_w = dx;
    assign dy_w = dy;
    assign d2 = 25'(dx_w * dx_w + dy_w * dy_w);

    // aging of current entry
    logic [7:0] aged;
    logic       keep;
    assign aged = (!rd_hit && rd_miss != 8'hff) ? rd_miss + 8'd1 : rd_miss;
    assign keep = aged < r_miss_limit;

    logic [IW-1:0] idx_i;
    assign idx_i = r_idx[IW-1:0];
    logic match;
    assign match = r_found && (r_lhs < r_rhs);
    logic full;
    assign full = r_used == CW'(MAX_TRACKS);

    // class of a matched track equals the blob class
    logic [3:0] rd_cls_best;
    assign rd_cls_best = r_cls;

    assign mem_ra = idx_i;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_best;
        mem_wd = {r_x, r_y, r_cls, 8'd0, 1'b1};
        if (i_cmd.finish_blob) begin
            if (match) begin
                mem_we = 1'b1;
                mem_wd = {r_x, r_y, rd_cls_best, 8'd0, 1'b1};
            end else if (!full) begin
                mem_we = 1'b1;
                mem_wa = r_used[IW-1:0];
                mem_wd = {r_x, r_y, r_cls, 8'd0, !r_init};
            end
        end else if (i_cmd.age_eval && keep && !r_init) begin
            // an initial frame leaves the table untouched
            mem_we = 1'b1;
            mem_wa = r_wr[IW-1:0];
            mem_wd = {rd_x, rd_y, rd_cls, aged, 1'b0};
        end
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_limit <= MISS_LIMIT_RST;
            r_gate_pct <= GATE_PCT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MISS_LIMIT) r_miss_limit <= i_cfg_data;
            else r_gate_pct <= i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_x <= i_center_x;
            r_y <= i_center_y;
            r_diag <= i_diagonal;
            r_cls <= i_color_class;
        end
    end

    // scan, gate and aging datapath
    // index of entry whose data is in r_rd during scan_eval is r_idx-1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_await <= 1'b1;
            r_init <= 1'b1;
            r_idx <= '0;
            r_wr <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
                r_wr <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_rd || i_cmd.age_rd) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.scan_eval && !r_init && rd_cls == r_cls
                && (!r_found || d2 < r_best_d2)) begin
                r_found <= 1'b1;
                r_best <= IW'(r_idx - CW'(1));
                r_best_d2 <= d2;
            end
            if (i_cmd.age_eval && keep) begin
                r_wr <= r_wr + CW'(1);
            end
            if (i_cmd.finish_blob && !match && !full) begin
                r_used <= r_used + CW'(1);
                r_await <= 1'b0;
            end
            if (i_cmd.finish_eof) begin
                if (!r_init) r_used <= r_wr;
                r_init <= r_await;
            end
        end
    end

    // gate products: gate^2, then distance term
    always_ff @(posedge i_clk) begin
        if (i_cmd.gate_mul1) begin
            r_gsq <= r_gate_pct * r_gate_pct;
        end
        if (i_cmd.gate_mul2) begin
            r_lhs <= 50'(r_best_d2) * 50'd10000;
        end
    end

    // full rhs product in two registered steps
    logic [28:0] r_gd;
    logic        r_step;
    always_ff @(posedge i_clk) begin
        if (i_cmd.gate_mul2) begin
            r_gd <= 29'(r_gsq) * 29'(r_diag);
        end
        r_step <= i_cmd.gate_mul2;
        if (r_step) begin
            r_rhs <= 50'(r_gd) * 50'(r_diag);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_cmd) begin
                r_status <= ST_CLOSED;
                r_slot <= '0;
                r_cnt <= 7'(r_init ? r_used : r_wr);
            end else if (match) begin
                r_status <= ST_MATCHED;
                r_slot <= 6'(r_best);
                r_cnt <= 7'(r_used);
            end else if (full) begin
                r_status <= ST_FULL;
                r_slot <= '0;
                r_cnt <= 7'(r_used);
            end else begin
                r_status <= ST_NEW;
                r_slot <= 6'(r_used);
                r_cnt <= 7'(r_used + CW'(1));
            end
        end
    end

    assign o_status = r_status;
    assign o_slot = r_slot;
    assign o_track_count = r_cnt;

    assign o_sts.is_eof = r_cmd;
    assign o_sts.scan_last = r_idx >= r_used;
    assign o_sts.age_last = r_idx >= r_used;
    assign o_sts.empty = r_used == '0;

endmodule

FILE: rtl/bntm_ctrl.sv
module bntm_ctrl
    import bntm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_DRAIN1 = 4'd3;
    localparam logic [3:0] S_DRAIN2 = 4'd4;
    localparam logic [3:0] S_G1 = 4'd5;
    localparam logic [3:0] S_G2 = 4'd6;
    localparam logic [3:0] S_G3 = 4'd7;
    localparam logic [3:0] S_G4 = 4'd8;
    localparam logic [3:0] S_FIN = 4'd9;
    localparam logic [3:0] S_AGE = 4'd10;
    localparam logic [3:0] S_AD1 = 4'd11;
    localparam logic [3:0] S_AD2 = 4'd12;
    localparam logic [3:0] S_EFIN = 4'd13;
    localparam logic [3:0] S_OUT = 4'd14;

    logic [3:0] r_state, n_state;
    logic r_ev1, n_ev1;
    logic r_ovalid, n_ovalid;

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_ovalid;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        n_ev1 = 1'b0;
        n_ovalid = r_ovalid && i_stall;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: n_state = i_sts.is_eof ? S_AGE : S_SCAN;
            S_SCAN: begin
                if (i_sts.scan_last) n_state = S_DRAIN1;
                else begin
                    o_cmd.scan_rd = 1'b1;
                    n_ev1 = 1'b1;
                end
            end
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_G1;
            S_G1: begin o_cmd.gate_mul1 = 1'b1; n_state = S_G2; end
            S_G2: begin o_cmd.gate_mul2 = 1'b1; n_state = S_G3; end
            S_G3: n_state = S_G4;
            S_G4: n_state = S_FIN;
            S_FIN: begin
                if (!r_ovalid) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.finish_blob = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_AGE: begin
                if (i_sts.age_last) n_state = S_AD1;
                else begin
                    o_cmd.age_rd = 1'b1;
                    n_ev1 = 1'b1;
                end
            end
            S_AD1: n_state = S_AD2;
            S_AD2: n_state = S_EFIN;
            S_EFIN: begin
                if (!r_ovalid) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.finish_eof = 1'b1;
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // read data is valid in the cycle after the read is issued
        if (r_ev1) begin
            o_cmd.scan_eval = !i_sts.is_eof;
            o_cmd.age_eval = i_sts.is_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ev1 <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ev1 <= n_ev1;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

FILE: rtl/blob_nearest_track_match_core.sv
// Nearest-track matcher: each blob request scans the stored tracks one per cycle
// through a track memory with one read port and one write port, and an end of frame
// runs an aging and compaction pass over the same memory. One request is in work at
// a time; the result register lets the next request be taken while the previous
// result waits. Entries above the track count are never read, so the memory needs
// no clearing after reset.
module blob_nearest_track_match_core
    import bntm_pkg::*;
#(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [11:0] i_center_x,
    input  logic [11:0] i_center_y,
    input  logic [12:0] i_diagonal,
    input  logic [3:0]  i_color_class,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot,
    output logic [6:0]  o_track_count
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    bntm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .o_cmd(cmd), .i_sts(sts)
    );

    // track table and arithmetic
    bntm_datapath #(.MAX_TRACKS(MAX_TRACKS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_command(i_command), .i_center_x(i_center_x), .i_center_y(i_center_y),
        .i_diagonal(i_diagonal), .i_color_class(i_color_class),
        .o_status(o_status), .o_slot(o_slot), .o_track_count(o_track_count)
    );

endmodule

FILE: rtl/bntm_checker.sv
module bntm_checker
    import bntm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic [5:0] o_slot,
    input logic [6:0] o_track_count
);

    // held result status and slot stay put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_slot))
        else $error("result changed under stall");

    // closed frame and dropped blob report slot zero
    a_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_CLOSED || o_status == ST_FULL) |-> o_slot == 6'd0)
        else $error("slot not zero");

    // new track sits at the end of the table
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_NEW |-> 7'(o_slot) + 7'd1 == o_track_count)
        else $error("new track slot mismatch");

    // full report only with full table
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_track_count == 7'(MAX_TRACKS_DEF))
        else $error("full with free room");

endmodule

bind blob_nearest_track_match_core bntm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_status(o_status), .o_slot(o_slot), .o_track_count(o_track_count)
);
